/* src/key_nonce_reuse_detector_core_defines.svh */
// assertion helpers used by knrd_dp
`ifndef KEY_NONCE_REUSE_DETECTOR_CORE_DEFINES_SVH
`define KEY_NONCE_REUSE_DETECTOR_CORE_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define KNRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define KNRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/knrd_pkg.sv */
package knrd_pkg;

  localparam int HIST_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int KEY_W      = 256;
  localparam int NONCE_W    = 96;
  localparam int PAIR_W     = KEY_W + NONCE_W;

  typedef logic [PAIR_W-1:0] pair_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_REPORT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan;
    logic append;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enabled;
    logic issue_done;
    logic rd_pending;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

/* src/knrd_ctrl.sv */
module knrd_ctrl
  import knrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    cfg_valid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    in_stall,
  output logic    cfg_ready
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) begin
          state_nxt = sts.enabled ? ST_SCAN : ST_REPORT;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          state_nxt = ST_REPORT;
        end else if (sts.issue_done && !sts.rd_pending) begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // a pending config write goes first, the input waits while cfg_valid is up
        in_stall    = cfg_valid;
        cfg_ready   = 1'b1;
        cmd.capture = in_valid && !cfg_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
      end
      ST_REPORT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/knrd_dp.sv */
`include "key_nonce_reuse_detector_core_defines.svh"

module knrd_dp
  import knrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [63:0]        key_word_0,
  input  logic [63:0]        key_word_1,
  input  logic [63:0]        key_word_2,
  input  logic [63:0]        key_word_3,
  input  logic [31:0]        nonce_high,
  input  logic [63:0]        nonce_low,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               reuse_found,
  output logic [CNT_W-1:0]   history_count
);

  pair_t              mem_r [HIST_DEPTH];
  pair_t              pair_r;
  pair_t              rd_data_r;
  logic               rd_vld_r;
  logic               rd_vld_nxt;
  logic [CNT_W-1:0]   issue_idx_r;
  logic [CNT_W-1:0]   issue_idx_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [SLOT_W-1:0]  oldest_r;
  logic [SLOT_W-1:0]  oldest_nxt;
  logic               enable_r;
  logic               enable_nxt;
  logic               found_r;
  logic               found_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_reuse_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  wr_addr;
  logic               full;
  logic               hit;
  logic               out_free;

  assign full     = (count_r == CNT_W'(HIST_DEPTH));
  assign hit      = rd_vld_r && (rd_data_r == pair_r);
  assign out_free = !out_valid_r || !out_stall;
  assign rd_en    = cmd.scan && (issue_idx_r != count_r);
  assign rd_addr  = oldest_r + issue_idx_r[SLOT_W-1:0];
  assign wr_addr  = full ? oldest_r : (oldest_r + count_r[SLOT_W-1:0]);

  // history memory, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
    if (cmd.append) begin
      mem_r[wr_addr] <= pair_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pair_r <= {key_word_0, key_word_1, key_word_2, key_word_3, nonce_high, nonce_low};
    end
    if (cmd.load_out) begin
      out_reuse_r <= found_r;
      out_count_r <= count_r;
    end
  end

  always_comb begin
    issue_idx_nxt = issue_idx_r;
    rd_vld_nxt    = 1'b0;
    found_nxt     = found_r;
    if (cmd.capture) begin
      issue_idx_nxt = '0;
      found_nxt     = 1'b0;
    end else if (cmd.scan) begin
      rd_vld_nxt = rd_en;
      found_nxt  = found_r || hit;
      if (rd_en) begin
        issue_idx_nxt = issue_idx_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    enable_nxt = enable_r;
    if (cfg_we) begin
      enable_nxt = cfg_data;
      if (!cfg_data) begin
        count_nxt  = '0;
        oldest_nxt = '0;
      end
    end else if (cmd.append) begin
      if (full) begin
        oldest_nxt = oldest_r + SLOT_W'(1);
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      issue_idx_r <= '0;
      found_r     <= 1'b0;
      count_r     <= '0;
      oldest_r    <= '0;
      enable_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= rd_vld_nxt;
      issue_idx_r <= issue_idx_nxt;
      found_r     <= found_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      enable_r    <= enable_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    sts.enabled    = enable_r;
    sts.issue_done = (issue_idx_r == count_r);
    sts.rd_pending = rd_vld_r;
    sts.hit        = hit;
    sts.out_free   = out_free;
  end

  assign out_valid     = out_valid_r;
  assign reuse_found   = out_reuse_r;
  assign history_count = out_count_r;

  `KNRD_ASSERT(a_count_bound, count_r <= CNT_W'(HIST_DEPTH), "history count above depth")
  `KNRD_ASSERT(a_no_overwrite, !cmd.load_out || out_free, "result register overwritten")
  `KNRD_ASSERT_NEXT(a_cfg_clear, cfg_we && !cfg_data, count_r == '0 && oldest_r == '0,
                    "disable did not empty history")
  `KNRD_ASSERT_NEXT(a_hit_no_append, cmd.scan && hit, !cmd.append, "append after hit")

endmodule

/* src/key_nonce_reuse_detector_core.sv */
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------------------
// in_       | input     | in_valid/in_stall  | key_word_0..3, nonce_high, nonce_low
// out_      | output    | out_valid/out_stall| out_reuse_found, out_history_count
// cfg_      | input     | cfg_valid/cfg_ready| cfg_data (detection enable)
//
// one transaction in flight: with n pairs held the scan reads one stored pair per cycle,
// then appends the pair and reports; the next input is taken only after the result is
// loaded into the result register; a hit stops the scan early and skips the append
// detection off: the input goes straight to report, with no scan and no append
// reset is synchronous active low: history empty, detection enabled
// in_stall is high outside idle and while cfg_valid is up; a held result stalls one item
module key_nonce_reuse_detector_core
  import knrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_key_word_0,
  input  logic [63:0]        in_key_word_1,
  input  logic [63:0]        in_key_word_2,
  input  logic [63:0]        in_key_word_3,
  input  logic [31:0]        in_nonce_high,
  input  logic [63:0]        in_nonce_low,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_reuse_found,
  output logic [CNT_W-1:0]   out_history_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // config register write only lands while the controller is idle
  assign cfg_we = cfg_valid && cfg_ready;

  // sequencer: idle, scan history, append, report
  knrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  // history ring memory, pointers, compare and result register
  knrd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .key_word_0    (in_key_word_0),
    .key_word_1    (in_key_word_1),
    .key_word_2    (in_key_word_2),
    .key_word_3    (in_key_word_3),
    .nonce_high    (in_nonce_high),
    .nonce_low     (in_nonce_low),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reuse_found   (out_reuse_found),
    .history_count (out_history_count)
  );

endmodule
